>>> design/prq_pkg.sv
// Shared types, request and status codes, and default sizes of the ready queue scheduler.
package prq_pkg;

   localparam int DEF_MAX_TASKS     = 16;
   localparam int DEF_PRIORITY_BITS = 8;
   localparam int DEF_COUNTER_BITS  = 16;

   localparam int KIND_W   = 3;
   localparam int TASK_W   = 4;
   localparam int PRIO_W   = 8;
   localparam int SLICE_W  = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [KIND_W-1:0] {
      REQ_ENQUEUE = 3'd0,
      REQ_DEQUEUE = 3'd1,
      REQ_PICK    = 3'd2,
      REQ_LOAD    = 3'd3,
      REQ_TICK    = 3'd4
   } req_kind_type;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALREADY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_QUEUED = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [TASK_W-1:0]  task_id;
      logic [PRIO_W-1:0]  prio;
      logic [SLICE_W-1:0] slice;
   } req_item_type;

   typedef struct packed {
      logic [TASK_W-1:0]   picked_task;
      logic                idle;
      logic                resched;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  running_count;
   } rsp_item_type;

   typedef struct packed {
      logic ready;
      logic done;
   } core_stat_type;

endpackage

>>> design/prq_core.sv
// Request sequencer of the ready queue: task entry and slice memories, scan and rank sweeps.
module prq_core
   import prq_pkg::*;
#(
   parameter int MAX_TASKS     = DEF_MAX_TASKS,
   parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
   parameter int COUNTER_BITS  = DEF_COUNTER_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_item_type  req,
   input  logic          take,
   output core_stat_type stat,
   output rsp_item_type  rsp
);

   localparam int IW = $clog2(MAX_TASKS);
   localparam int RB = IW;
   localparam int PB = PRIORITY_BITS;
   localparam int CB = COUNTER_BITS;
   localparam int EW = PB + RB;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEQ_RANK,
      ST_TICK,
      ST_INSERT,
      ST_SCAN,
      ST_REMOVE,
      ST_FINISH
   } state_type;

   // entry memory: {priority, recency rank}, rank 0 is the newest queued task
   logic [EW-1:0] ent_mem [MAX_TASKS];
   logic [EW-1:0] ent_rd_ff;
   logic [IW-1:0] ent_raddr;
   logic          ent_we;
   logic [IW-1:0] ent_waddr;
   logic [EW-1:0] ent_wdata;

   logic [CB-1:0] slc_mem [MAX_TASKS];
   logic [CB-1:0] slc_rd_ff;
   logic          slc_we;
   logic [IW-1:0] slc_waddr;
   logic [CB-1:0] slc_wdata;

   state_type     state_ff, state_in;
   logic [IW-1:0] tidx_ff, tidx_in;
   logic [PB-1:0] prio_ff, prio_in;
   logic          queued_ff [MAX_TASKS];
   logic          queued_in [MAX_TASKS];
   logic          slc_vld_ff [MAX_TASKS];
   logic          slc_vld_in [MAX_TASKS];
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] sweep_ff, sweep_in;
   logic          issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          best_found_ff, best_found_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [PB-1:0] best_prio_ff, best_prio_in;
   logic [RB-1:0] best_rank_ff, best_rank_in;
   logic [RB-1:0] rem_rank_ff, rem_rank_in;
   logic [IW-1:0] res_picked_ff, res_picked_in;
   logic          res_idle_ff, res_idle_in;
   logic          res_resched_ff, res_resched_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic [IW-1:0] req_tidx;
   logic          id_ok;
   logic [PB-1:0] rd_prio;
   logic [RB-1:0] rd_rank;
   logic          sweep_done;
   logic [CB-1:0] cur_slice;

   assign req_tidx   = IW'(req.task_id);
   assign id_ok      = 32'(req.task_id) < MAX_TASKS;
   assign rd_prio    = ent_rd_ff[EW-1:RB];
   assign rd_rank    = ent_rd_ff[RB-1:0];
   assign sweep_done = !issue_ff && !pend_ff;
   assign cur_slice  = slc_vld_ff[tidx_ff] ? slc_rd_ff : '0;
   assign ent_raddr  = (state_ff == ST_IDLE) ? req_tidx : sweep_ff;

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rd_ff <= ent_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (slc_we) begin
         slc_mem[slc_waddr] <= slc_wdata;
      end
      slc_rd_ff <= slc_mem[req_tidx];
   end

   always_comb begin
      state_in       = state_ff;
      tidx_in        = tidx_ff;
      prio_in        = prio_ff;
      queued_in      = queued_ff;
      slc_vld_in     = slc_vld_ff;
      count_in       = count_ff;
      sweep_in       = sweep_ff;
      issue_in       = 1'b0;
      pend_in        = 1'b0;
      rd_idx_in      = rd_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_prio_in   = best_prio_ff;
      best_rank_in   = best_rank_ff;
      rem_rank_in    = rem_rank_ff;
      res_picked_in  = res_picked_ff;
      res_idle_in    = res_idle_ff;
      res_resched_in = res_resched_ff;
      res_status_in  = res_status_ff;
      ent_we         = 1'b0;
      ent_waddr      = rd_idx_ff;
      ent_wdata      = ent_rd_ff;
      slc_we         = 1'b0;
      slc_waddr      = tidx_ff;
      slc_wdata      = '0;

      // advance the sweep: issue one read per cycle and process it in the cycle after
      if (issue_ff) begin
         pend_in   = 1'b1;
         rd_idx_in = sweep_ff;
         sweep_in  = sweep_ff + IW'(1);
         issue_in  = (sweep_ff != LAST_IDX);
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               tidx_in        = req_tidx;
               prio_in        = PB'(req.prio);
               res_picked_in  = '0;
               res_idle_in    = 1'b0;
               res_resched_in = 1'b0;
               res_status_in  = STATUS_OK;
               sweep_in       = '0;
               state_in       = ST_FINISH;
               if (req.kind == REQ_PICK) begin
                  if (count_ff == '0) begin
                     res_idle_in = 1'b1;
                  end else begin
                     best_found_in = 1'b0;
                     issue_in      = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end else if (req.kind <= REQ_TICK && !id_ok) begin
                  res_status_in = STATUS_NOT_QUEUED;
               end else begin
                  case (req.kind)
                     REQ_ENQUEUE: begin
                        if (queued_ff[req_tidx]) begin
                           res_status_in = STATUS_ALREADY;
                        end else begin
                           issue_in = 1'b1;
                           state_in = ST_INSERT;
                        end
                     end
                     REQ_DEQUEUE: begin
                        if (!queued_ff[req_tidx]) begin
                           res_status_in = STATUS_NOT_QUEUED;
                        end else begin
                           queued_in[req_tidx] = 1'b0;
                           count_in            = count_ff - CW'(1);
                           state_in            = ST_DEQ_RANK;
                        end
                     end
                     REQ_LOAD: begin
                        slc_we               = 1'b1;
                        slc_waddr            = req_tidx;
                        slc_wdata            = CB'(req.slice);
                        slc_vld_in[req_tidx] = 1'b1;
                     end
                     REQ_TICK: begin
                        state_in = ST_TICK;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_DEQ_RANK: begin
            rem_rank_in = rd_rank;
            sweep_in    = '0;
            issue_in    = 1'b1;
            state_in    = ST_REMOVE;
         end
         ST_TICK: begin
            slc_we              = 1'b1;
            slc_vld_in[tidx_ff] = 1'b1;
            if (cur_slice <= CB'(1)) begin
               slc_wdata      = '0;
               res_resched_in = 1'b1;
            end else begin
               slc_wdata = cur_slice - CB'(1);
            end
            state_in = ST_FINISH;
         end
         ST_INSERT: begin
            // age every queued task, then place the new one at rank zero
            if (pend_ff && queued_ff[rd_idx_ff]) begin
               ent_we    = 1'b1;
               ent_wdata = {rd_prio, rd_rank + RB'(1)};
            end
            if (sweep_done) begin
               ent_we             = 1'b1;
               ent_waddr          = tidx_ff;
               ent_wdata          = {prio_ff, RB'(0)};
               queued_in[tidx_ff] = 1'b1;
               count_in           = count_ff + CW'(1);
               state_in           = ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (pend_ff && queued_ff[rd_idx_ff]) begin
               if (!best_found_ff || rd_prio > best_prio_ff ||
                   (rd_prio == best_prio_ff && rd_rank < best_rank_ff)) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_prio_in  = rd_prio;
                  best_rank_in  = rd_rank;
               end
            end
            if (sweep_done) begin
               queued_in[best_idx_ff] = 1'b0;
               count_in               = count_ff - CW'(1);
               rem_rank_in            = best_rank_ff;
               res_picked_in          = best_idx_ff;
               sweep_in               = '0;
               issue_in               = 1'b1;
               state_in               = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            // close the gap left in the rank order
            if (pend_ff && queued_ff[rd_idx_ff] && rd_rank > rem_rank_ff) begin
               ent_we    = 1'b1;
               ent_wdata = {rd_prio, rd_rank - RB'(1)};
            end
            if (sweep_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tidx_ff        <= tidx_in;
      prio_ff        <= prio_in;
      sweep_ff       <= sweep_in;
      rd_idx_ff      <= rd_idx_in;
      best_found_ff  <= best_found_in;
      best_idx_ff    <= best_idx_in;
      best_prio_ff   <= best_prio_in;
      best_rank_ff   <= best_rank_in;
      rem_rank_ff    <= rem_rank_in;
      res_picked_ff  <= res_picked_in;
      res_idle_ff    <= res_idle_in;
      res_resched_ff <= res_resched_in;
      res_status_ff  <= res_status_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         queued_ff  <= '{default: 1'b0};
         slc_vld_ff <= '{default: 1'b0};
         count_ff   <= '0;
         issue_ff   <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         queued_ff  <= queued_in;
         slc_vld_ff <= slc_vld_in;
         count_ff   <= count_in;
         issue_ff   <= issue_in;
         pend_ff    <= pend_in;
      end
   end

   assign stat.ready = (state_ff == ST_IDLE);
   assign stat.done  = (state_ff == ST_FINISH);

   assign rsp.picked_task   = TASK_W'(res_picked_ff);
   assign rsp.idle          = res_idle_ff;
   assign rsp.resched       = res_resched_ff;
   assign rsp.status        = res_status_ff;
   assign rsp.running_count = COUNT_W'(count_ff);

endmodule

>>> design/priority_ready_queue_scheduler.sv
// Top level of the priority ready queue scheduler: request intake and response register.
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_stall    req_type, req_task_id, req_priority_req,
//                                                req_slice_value
//   rsp      out        rsp_valid / rsp_stall    rsp_picked_task, rsp_idle, rsp_resched,
//                                                rsp_status, rsp_running_count
//
// One request at a time. Load and rejected requests finish directly, tick reads and then
// writes the slice; enqueue and dequeue (after a rank read) run the rank sweep through the
// entry memory (one entry read per cycle); pick next runs a scan, then the rank sweep.
// Reset clears the queued and slice-valid bits at once; no clearing pass.
// A waiting response does not block intake; a finished request holds until the response
// register is free.
module priority_ready_queue_scheduler
   import prq_pkg::*;
#(
   parameter int MAX_TASKS     = DEF_MAX_TASKS,
   parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
   parameter int COUNTER_BITS  = DEF_COUNTER_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_type,
   input  logic [TASK_W-1:0]   req_task_id,
   input  logic [PRIO_W-1:0]   req_priority_req,
   input  logic [SLICE_W-1:0]  req_slice_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [TASK_W-1:0]   rsp_picked_task,
   output logic                rsp_idle,
   output logic                rsp_resched,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_running_count
);

   req_item_type  req_item;
   rsp_item_type  core_rsp;
   core_stat_type core_stat;
   logic          start;
   logic          take;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff, rsp_in;

   assign req_item.kind    = req_type;
   assign req_item.task_id = req_task_id;
   assign req_item.prio    = req_priority_req;
   assign req_item.slice   = req_slice_value;

   assign req_stall = !core_stat.ready;
   assign start     = req_valid && core_stat.ready;
   // the response register can take a new request result when empty or draining
   assign take      = !rsp_valid_ff || !rsp_stall;

   prq_core #(
      .MAX_TASKS     (MAX_TASKS),
      .PRIORITY_BITS (PRIORITY_BITS),
      .COUNTER_BITS  (COUNTER_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req_item),
      .take  (take),
      .stat  (core_stat),
      .rsp   (core_rsp)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (core_stat.done && take) begin
         rsp_in       = core_rsp;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_picked_task   = rsp_ff.picked_task;
   assign rsp_idle          = rsp_ff.idle;
   assign rsp_resched       = rsp_ff.resched;
   assign rsp_status        = rsp_ff.status;
   assign rsp_running_count = rsp_ff.running_count;

endmodule
